// ===== rtl/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants of the 7x7 separable box mean filter.
// ----------------------------------------------------------------------------
package sbm_pkg;

   localparam int PIX_W       = 8;   // input pixel
   localparam int HSUM_W      = 11;  // seven-pixel horizontal sum
   localparam int VSUM_W      = 14;  // seven horizontal sums
   localparam int MEAN_W      = 8;
   localparam int ROW_W       = 16;
   localparam int OUT_COL_W   = 10;
   localparam int CFG_WIDTH_W = 11;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 1;

   localparam int WIN       = 7;     // window edge
   localparam int BORDER    = 3;     // distance of the centre from the window edge
   localparam int NUM_LINES = 6;     // stored rows of horizontal sums
   localparam int SLOT_W    = 3;

   // floor(v / 49) == (v * 21400) >> 20 for every v below 2**14.
   localparam int RECIP_W   = 15;
   localparam int DIV_RECIP = 21400;
   localparam int DIV_SHIFT = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd480;

   typedef logic [PIX_W-1:0]  pixel_type;
   typedef logic [HSUM_W-1:0] hsum_type;
   typedef logic [SLOT_W-1:0] slot_type;

endpackage

// ===== rtl/sbm_ram.sv =====
// ----------------------------------------------------------------------------
// sbm_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/separable_box_mean_7x7_unit.sv =====
// ----------------------------------------------------------------------------
// separable_box_mean_7x7_unit
// 7x7 box mean of a raster-order greyscale stream, built from horizontal sums
// and six line stores of those sums.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order, one request per pixel.
// For each pixel whose window centre lies at least three pixels from every
// border, one result leaves on the rsp_ channel: the truncated mean of the
// 7x7 window, the centre's row and column, and rsp_last on the final interior
// result of the frame. Border pixels are consumed without a result.
// Image width and height are set through the csr_ write port; the user must do so
// only while the block is idle, which the block does not enforce. Widths above
// MAX_WIDTH are clipped to MAX_WIDTH. Throughput is one pixel per clock while the
// receiver keeps up. The line store word of a pixel is read at the edge that
// accepts it; stage B then adds the window and writes the word back, and stage C
// multiplies by the reciprocal of 49 into the output register.
// The line store is a single RAM word per column holding all six stored rows,
// so one read and one write per pixel keep up with the stream.
// When the receiver stalls, the output register holds its result while stage
// C and stage B still fill, so up to three window results are held before
// req_ready drops; border pixels take a place in stage B but not in stage C.
// Reset clears the counters, the pixel history and all valid flags; the line
// store needs no clearing, since every entry is written before a window
// reads it.
// ----------------------------------------------------------------------------
module separable_box_mean_7x7_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sbm_pkg::PIX_W-1:0]           req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sbm_pkg::MEAN_W-1:0]          rsp_mean,
   output logic [sbm_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [sbm_pkg::OUT_COL_W-1:0]       rsp_out_col,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [sbm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import sbm_pkg::*;

   // Column counter and RAM address width, the widened compare width for the
   // effective image width, and the width used to form the centre column.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int EW     = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
   localparam int OC_W   = (COL_W > OUT_COL_W) ? COL_W : OUT_COL_W;
   localparam int WORD_W = NUM_LINES * HSUM_W;
   localparam int PROD_W = VSUM_W + RECIP_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [CFG_WIDTH_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0]       height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[ROW_W-1:0];
            default:          ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake and stage control
   // ---------------------------------------------------------------------
   // Stage B holds the request whose line store word is being read; stage C
   // holds a window sum waiting for the divide; the output register holds
   // the result. Each stage moves when the one after it is empty or moving.
   logic rsp_valid_ff, rsp_valid_in;
   logic b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in;
   logic out_free, c_free, b_free, b_move, accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign c_free    = !c_valid_ff || out_free;
   assign b_free    = !b_valid_ff || c_free;
   assign b_move    = b_valid_ff && c_free;
   assign req_ready = b_free;
   assign accept    = req_valid && b_free;

   // ---------------------------------------------------------------------
   // Stage A: position counters, pixel history and horizontal sum
   // ---------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   slot_type         slot_ff, slot_in;
   pixel_type        recent_ff [NUM_LINES];
   pixel_type        recent_in [NUM_LINES];

   logic [EW-1:0]    width_ext, eff_width, col_next;
   logic [ROW_W:0]   row_next;
   logic             wrap_col, wrap_row;
   hsum_type         hsum;
   logic             a_emit, a_store, a_last;
   logic [ROW_W-1:0] a_out_row;
   logic [OC_W-1:0]  a_out_col;

   assign width_ext = EW'(width_ff);
   assign eff_width = (width_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : width_ext;
   assign col_next  = EW'(col_ff) + EW'(1);
   assign row_next  = {1'b0, row_ff} + (ROW_W + 1)'(1);
   // A width or height of zero wraps after every pixel, like a value of one.
   assign wrap_col  = col_next >= eff_width;
   assign wrap_row  = row_next >= {1'b0, height_ff};

   always_comb begin
      hsum = hsum_type'(req_pixel);
      for (int i = 0; i < NUM_LINES; i++) begin
         hsum = hsum + hsum_type'(recent_ff[i]);
      end
   end

   // A full window needs six earlier columns and six earlier rows. Sums are
   // stored from the seventh column on, since earlier ones mix two rows.
   assign a_store   = col_ff >= COL_W'(WIN - 1);
   assign a_emit    = a_store && (row_ff >= ROW_W'(WIN - 1));
   assign a_last    = wrap_col && wrap_row;
   assign a_out_row = row_ff - ROW_W'(BORDER);
   assign a_out_col = OC_W'(col_ff) - OC_W'(BORDER);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      for (int i = 0; i < NUM_LINES; i++) begin
         recent_in[i] = recent_ff[i];
      end
      if (accept) begin
         recent_in[0] = req_pixel;
         for (int i = 1; i < NUM_LINES; i++) begin
            recent_in[i] = recent_ff[i-1];
         end
         col_in = col_next[COL_W-1:0];
         if (wrap_col) begin
            col_in = '0;
            if (wrap_row) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_next[ROW_W-1:0];
               slot_in = (slot_ff == slot_type'(NUM_LINES - 1)) ? '0 : slot_ff + slot_type'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Line store: one word per column, six horizontal sums per word
   // ---------------------------------------------------------------------
   logic              ram_we;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   logic [COL_W-1:0]     b_col_ff;
   hsum_type             b_hsum_ff;
   slot_type             b_slot_ff;
   logic                 b_emit_ff, b_store_ff, b_last_ff;
   logic [ROW_W-1:0]     b_out_row_ff;
   logic [OUT_COL_W-1:0] b_out_col_ff;

   sbm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock (clock),
      .we    (ram_we),
      .waddr (b_col_ff),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // Stage B: vertical sum and write-back of the current row's slot
   // ---------------------------------------------------------------------
   // The slot of the current row still holds the sum from six rows earlier,
   // which is part of this window, so all six slots are added before the
   // current sum replaces that slot.
   logic [VSUM_W-1:0] vsum;

   always_comb begin
      vsum      = VSUM_W'(b_hsum_ff);
      ram_wdata = ram_rdata;
      for (int i = 0; i < NUM_LINES; i++) begin
         vsum = vsum + VSUM_W'(ram_rdata[i*HSUM_W +: HSUM_W]);
         if (b_slot_ff == slot_type'(i)) begin
            ram_wdata[i*HSUM_W +: HSUM_W] = b_hsum_ff;
         end
      end
   end

   assign ram_we = b_move && b_store_ff;

   // ---------------------------------------------------------------------
   // Stage C and output register: divide by 49 through the reciprocal
   // ---------------------------------------------------------------------
   logic [VSUM_W-1:0]    c_vsum_ff;
   logic [ROW_W-1:0]     c_out_row_ff;
   logic [OUT_COL_W-1:0] c_out_col_ff;
   logic                 c_last_ff;
   logic [PROD_W-1:0]    prod;

   logic [MEAN_W-1:0]    rsp_mean_ff;
   logic [ROW_W-1:0]     rsp_out_row_ff;
   logic [OUT_COL_W-1:0] rsp_out_col_ff;
   logic                 rsp_last_ff;

   assign prod = PROD_W'(c_vsum_ff) * PROD_W'(DIV_RECIP);

   always_comb begin
      b_valid_in   = b_free ? accept : b_valid_ff;
      c_valid_in   = c_free ? (b_move && b_emit_ff) : c_valid_ff;
      rsp_valid_in = out_free ? c_valid_ff : rsp_valid_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         for (int i = 0; i < NUM_LINES; i++) begin
            recent_ff[i] <= '0;
         end
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         slot_ff      <= slot_in;
         for (int i = 0; i < NUM_LINES; i++) begin
            recent_ff[i] <= recent_in[i];
         end
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, loaded whenever its stage takes a new entry.
   always_ff @(posedge clock) begin
      if (accept) begin
         b_col_ff     <= col_ff;
         b_hsum_ff    <= hsum;
         b_slot_ff    <= slot_ff;
         b_emit_ff    <= a_emit;
         b_store_ff   <= a_store;
         b_last_ff    <= a_last;
         b_out_row_ff <= a_out_row;
         b_out_col_ff <= a_out_col[OUT_COL_W-1:0];
      end
      if (b_move) begin
         c_vsum_ff    <= vsum;
         c_out_row_ff <= b_out_row_ff;
         c_out_col_ff <= b_out_col_ff;
         c_last_ff    <= b_last_ff;
      end
      if (out_free && c_valid_ff) begin
         rsp_mean_ff    <= prod[DIV_SHIFT +: MEAN_W];
         rsp_out_row_ff <= c_out_row_ff;
         rsp_out_col_ff <= c_out_col_ff;
         rsp_last_ff    <= c_last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_mean    = rsp_mean_ff;
   assign rsp_out_row = rsp_out_row_ff;
   assign rsp_out_col = rsp_out_col_ff;
   assign rsp_last    = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The write-back never targets the column read in the same cycle, so the
   // line store needs no forwarding path.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && accept && (b_col_ff == col_ff)))
      else $error("line store read and write hit the same column");

   // The row slot always names one of the six stored rows.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff < slot_type'(NUM_LINES))
      else $error("row slot out of range");

   // A request held in stage B is never dropped while stage C is blocked.
   a_b_holds: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !c_free) |=> (b_valid_ff && $stable(b_col_ff)))
      else $error("stage B lost a stalled request");

   // Results only ever describe interior window centres.
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_out_row_ff >= ROW_W'(BORDER))
                        && (rsp_out_col_ff >= OUT_COL_W'(BORDER))))
      else $error("result for a border position");

endmodule
